// ----- hw/rtl/itws_pkg.sv -----
`timescale 1ns / 1ps

package itws_pkg;

  localparam int SLOT_W = 4;
  localparam int TS_W   = 32;
  localparam int SUM_W  = 36;
  localparam int CNT_W  = 5;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STOP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_STARTED  = 2'd0,
    STATUS_RECORDED = 2'd1,
    STATUS_IGNORED  = 2'd2
  } status_t;

  // what the finishing request sees of the slot
  typedef struct packed {
    logic is_stop;
    logic slot_ok;
    logic running;
    logic full;
  } ctx_t;

  // state changes decided for the finishing request
  typedef struct packed {
    logic start;
    logic record;
  } upd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    status_t           status;
    logic [TS_W-1:0]   duration;
    logic [SUM_W-1:0]  window_sum;
    logic [CNT_W-1:0]  window_count;
  } result_t;

endpackage

// ----- hw/rtl/itws_in_if.sv -----
`timescale 1ns / 1ps

interface itws_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [itws_pkg::SLOT_W-1:0]  slot;
  logic [itws_pkg::TS_W-1:0]    timestamp;

  modport source (output valid, output req_type, output slot, output timestamp, input ready);
  modport sink   (input valid, input req_type, input slot, input timestamp, output ready);
endinterface

// ----- hw/rtl/itws_out_if.sv -----
`timescale 1ns / 1ps

interface itws_out_if;
  logic                         valid;
  logic                         ready;
  logic [itws_pkg::SLOT_W-1:0]  slot_out;
  logic [1:0]                   status;
  logic [itws_pkg::TS_W-1:0]    duration;
  logic [itws_pkg::SUM_W-1:0]   window_sum;
  logic [itws_pkg::CNT_W-1:0]   window_count;

  modport source (
    output valid, output slot_out, output status, output duration,
    output window_sum, output window_count, input ready
  );
  modport sink (
    input valid, input slot_out, input status, input duration,
    input window_sum, input window_count, output ready
  );
endinterface

// ----- hw/rtl/itws_ram.sv -----
`timescale 1ns / 1ps

module itws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/itws_calc.sv -----
`timescale 1ns / 1ps

module itws_calc #(
  parameter int WINDOW = 16,
  localparam int CW = $clog2(WINDOW + 1),
  localparam int RW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  itws_pkg::ctx_t                    ctx,
  input  logic [itws_pkg::SLOT_W-1:0]       slot,
  input  logic [itws_pkg::TS_W-1:0]         timestamp,
  input  logic [itws_pkg::TS_W-1:0]         start_stamp,
  input  logic [itws_pkg::SUM_W-1:0]        sum_rdata,
  input  logic [itws_pkg::TS_W-1:0]         old_value,
  input  logic [CW-1:0]                     fill_cur,
  input  logic [RW-1:0]                     repl_cur,
  output itws_pkg::result_t                 result,
  output itws_pkg::upd_t                    upd,
  output logic [itws_pkg::SUM_W-1:0]        new_sum,
  output logic [itws_pkg::TS_W-1:0]         dur,
  output logic [CW-1:0]                     fill_nxt,
  output logic [RW-1:0]                     repl_nxt
);

  localparam int SUM_W = itws_pkg::SUM_W;

  logic [SUM_W-1:0] sum_cur;
  logic [SUM_W-1:0] sub_val;
  logic [CW-1:0]    cnt_sel;
  logic [31:0]      cnt_ext;

  // sum store holds nothing for a slot until its first recorded stop
  assign sum_cur = (fill_cur == '0) ? '0 : sum_rdata;
  assign dur     = timestamp - start_stamp;
  assign sub_val = ctx.full ? SUM_W'(old_value) : '0;
  assign new_sum = sum_cur - sub_val + SUM_W'(dur);

  assign upd.start  = ctx.slot_ok && !ctx.is_stop && !ctx.running;
  assign upd.record = ctx.slot_ok && ctx.is_stop && ctx.running;

  assign fill_nxt = ctx.full ? fill_cur : fill_cur + 1'b1;

  always_comb begin
    repl_nxt = repl_cur;
    if (ctx.full) begin
      repl_nxt = (repl_cur == RW'(WINDOW - 1)) ? '0 : repl_cur + 1'b1;
    end
  end

  assign cnt_sel = upd.record ? fill_nxt : fill_cur;
  assign cnt_ext = 32'(cnt_sel);

  always_comb begin
    result.slot_out     = slot;
    result.status       = itws_pkg::STATUS_IGNORED;
    result.duration     = '0;
    result.window_sum   = '0;
    result.window_count = '0;
    if (ctx.slot_ok) begin
      result.window_sum   = sum_cur;
      result.window_count = cnt_ext[itws_pkg::CNT_W-1:0];
      if (upd.start) begin
        result.status = itws_pkg::STATUS_STARTED;
      end else if (upd.record) begin
        result.status     = itws_pkg::STATUS_RECORDED;
        result.duration   = dur;
        result.window_sum = new_sum;
      end
    end
  end

endmodule

// ----- hw/rtl/interval_timer_window_sum_unit.sv -----
`timescale 1ns / 1ps

// interval timer with a per-slot sliding-window sum of durations
// in_ch carries requests: req_type (start or stop), slot and timestamp
// out_ch returns one result per request: slot_out, status, duration,
// window_sum and window_count of the slot after the request
// both channels use valid/ready; a request is taken when both are high
// each request passes through the request stage in phases: phase 0
// reads the slot's stamp, sum and ring entry from their memories,
// phase 1 does the read-modify-write and loads the result register
// a new request is taken while the stage is empty or as the one in flight finishes
// when the receiver stalls the result register holds and the request in
// flight waits in phase 1; a new request is taken the cycle the
// waiting one moves into the result register
// reset clears the running flags, fill counts and replace pointers at
// once; no clearing pass runs, the first request may follow reset directly
module interval_timer_window_sum_unit #(
  parameter int WINDOW = 16,
  parameter int SLOTS  = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  itws_in_if.sink         in_ch,
  itws_out_if.source      out_ch
);

  localparam int SIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int AW    = (SLOTS * WINDOW > 1) ? $clog2(SLOTS * WINDOW) : 1;
  localparam int TS_W  = itws_pkg::TS_W;
  localparam int SUM_W = itws_pkg::SUM_W;

  logic                        s1_valid_r;
  logic                        s1_phase_r;
  logic                        s1_req_r;
  logic [itws_pkg::SLOT_W-1:0] s1_slot_r;
  logic [TS_W-1:0]             s1_ts_r;

  logic          running_r [SLOTS];
  logic [CW-1:0] fill_r    [SLOTS];
  logic [RW-1:0] repl_r    [SLOTS];

  logic              out_valid_r;
  itws_pkg::result_t out_item_r;

  logic [31:0]       slot_ext;
  logic              slot_ok;
  logic [SIW-1:0]    idx;
  logic [CW-1:0]     fill_cur;
  logic [RW-1:0]     repl_cur;
  logic              full;
  logic [RW-1:0]     pos;
  logic [AW-1:0]     win_addr;
  logic              finish;
  logic              accept;

  logic [TS_W-1:0]   stamp_rdata;
  logic [SUM_W-1:0]  sum_rdata;
  logic [TS_W-1:0]   win_rdata;

  itws_pkg::ctx_t    ctx;
  itws_pkg::upd_t    upd;
  itws_pkg::result_t result;
  logic [SUM_W-1:0]  new_sum;
  logic [TS_W-1:0]   dur;
  logic [CW-1:0]     fill_nxt;
  logic [RW-1:0]     repl_nxt;

  assign slot_ext = 32'(s1_slot_r);
  assign slot_ok  = slot_ext < SLOTS;
  assign idx      = slot_ok ? slot_ext[SIW-1:0] : '0;
  assign fill_cur = fill_r[idx];
  assign repl_cur = repl_r[idx];
  assign full     = fill_cur >= CW'(WINDOW);
  assign pos      = full ? repl_cur : fill_cur[RW-1:0];
  assign win_addr = AW'(idx) * AW'(WINDOW) + AW'(pos);

  assign finish = s1_valid_r && s1_phase_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || finish;
  assign accept = in_ch.valid && in_ch.ready;

  assign ctx.is_stop = (s1_req_r == itws_pkg::REQ_STOP);
  assign ctx.slot_ok = slot_ok;
  assign ctx.running = running_r[idx];
  assign ctx.full    = full;

  itws_ram #(.WIDTH(TS_W), .DEPTH(SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (finish && upd.start),
    .waddr (idx),
    .wdata (s1_ts_r),
    .raddr (idx),
    .rdata (stamp_rdata)
  );

  itws_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_sum_ram (
    .clk   (clk),
    .we    (finish && upd.record),
    .waddr (idx),
    .wdata (new_sum),
    .raddr (idx),
    .rdata (sum_rdata)
  );

  itws_ram #(.WIDTH(TS_W), .DEPTH(SLOTS * WINDOW)) u_win_ram (
    .clk   (clk),
    .we    (finish && upd.record),
    .waddr (win_addr),
    .wdata (dur),
    .raddr (win_addr),
    .rdata (win_rdata)
  );

  itws_calc #(.WINDOW(WINDOW)) u_calc (
    .ctx         (ctx),
    .slot        (s1_slot_r),
    .timestamp   (s1_ts_r),
    .start_stamp (stamp_rdata),
    .sum_rdata   (sum_rdata),
    .old_value   (win_rdata),
    .fill_cur    (fill_cur),
    .repl_cur    (repl_cur),
    .result      (result),
    .upd         (upd),
    .new_sum     (new_sum),
    .dur         (dur),
    .fill_nxt    (fill_nxt),
    .repl_nxt    (repl_nxt)
  );

  // request stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      s1_phase_r <= 1'b0;
    end else if (finish) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (s1_valid_r) begin
      s1_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r  <= in_ch.req_type;
      s1_slot_r <= in_ch.slot;
      s1_ts_r   <= in_ch.timestamp;
    end
  end

  // per-slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        running_r[i] <= 1'b0;
        fill_r[i]    <= '0;
        repl_r[i]    <= '0;
      end
    end else if (finish) begin
      if (upd.start) begin
        running_r[idx] <= 1'b1;
      end
      if (upd.record) begin
        running_r[idx] <= 1'b0;
        fill_r[idx]    <= fill_nxt;
        repl_r[idx]    <= repl_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot_out     = out_item_r.slot_out;
  assign out_ch.status       = out_item_r.status;
  assign out_ch.duration     = out_item_r.duration;
  assign out_ch.window_sum   = out_item_r.window_sum;
  assign out_ch.window_count = out_item_r.window_count;

endmodule

// ----- hw/rtl/itws_checker.sv -----
`timescale 1ns / 1ps

module itws_checker #(
  parameter int WINDOW = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  status,
  input logic [itws_pkg::TS_W-1:0]   duration,
  input logic [itws_pkg::CNT_W-1:0]  window_count
);

  // a result waiting for the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a taken request keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still reading");

  // only a recorded stop reports a duration
  a_dur_only_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != itws_pkg::STATUS_RECORDED) |-> duration == '0)
    else $error("duration on a result that recorded nothing");

  // the window never reports more entries than it holds
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(window_count) <= WINDOW)
    else $error("window count above window length");

endmodule

bind interval_timer_window_sum_unit itws_checker #(.WINDOW(WINDOW)) u_itws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .duration     (out_ch.duration),
  .window_count (out_ch.window_count)
);
